@@ design/wtls_certificate_field_parser_assert.svh @@
// ---------------------------------------------------------------------------
// WTLS certificate field parser assertion macros
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is defined.
// ---------------------------------------------------------------------------
`ifndef WTLS_CERTIFICATE_FIELD_PARSER_ASSERT_SVH
`define WTLS_CERTIFICATE_FIELD_PARSER_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication, disabled during reset
`define WCFP_ASSERT(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication, disabled during reset
`define WCFP_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error(msg);
`else
`define WCFP_ASSERT(lbl, clk_s, rstn_s, ante, cons, msg)
`define WCFP_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg)
`endif

`endif

@@ design/wcfp_pkg.sv @@
// ---------------------------------------------------------------------------
// wcfp_pkg
// Field codes, status codes, register indexes, item types and phase helpers.
// ---------------------------------------------------------------------------
package wcfp_pkg;

	// parse phases, which double as field codes
	localparam logic [4:0] PH_VERSION  = 5'd0;
	localparam logic [4:0] PH_ISS_ID   = 5'd2;
	localparam logic [4:0] PH_ISS_NLEN = 5'd4;
	localparam logic [4:0] PH_NBEFORE  = 5'd6;
	localparam logic [4:0] PH_NAFTER   = 5'd7;
	localparam logic [4:0] PH_SUB_ID   = 5'd8;
	localparam logic [4:0] PH_SUB_NLEN = 5'd10;
	localparam logic [4:0] PH_KEY_ALG  = 5'd12;
	localparam logic [4:0] PH_PARAM    = 5'd13;
	localparam logic [4:0] PH_EXP_LEN  = 5'd14;
	localparam logic [4:0] PH_MOD_LEN  = 5'd16;
	localparam logic [4:0] PH_MODULUS  = 5'd17;
	localparam logic [4:0] PH_SIGLEN   = 5'd19;
	localparam logic [4:0] PH_SIG      = 5'd20;
	localparam logic [4:0] PH_DONE     = 5'd21;

	// status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_BAD_ID  = 3'd1;
	localparam logic [2:0] ST_BAD_KEY = 3'd2;
	localparam logic [2:0] ST_PARAM   = 3'd3;
	localparam logic [2:0] ST_LEN     = 3'd4;
	localparam logic [2:0] ST_TRUNC   = 3'd5;

	// configuration register indexes
	localparam logic [1:0] REG_EXP_LEN  = 2'd0;
	localparam logic [1:0] REG_TEXT_ID  = 2'd1;
	localparam logic [1:0] REG_RSA_CODE = 2'd2;

	localparam logic [17:0] COUNT_MAX      = 18'h3FFFF;
	localparam logic [7:0]  PARAM_RESERVED = 8'd255;

	// classified byte handed from front to back
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last;
		logic       id_ok;
		logic       key_ok;
		logic       is_reserved;
	} mid_item_t;

	// one result item
	typedef struct packed {
		logic [4:0]  field_code;
		logic [7:0]  field_byte;
		logic [15:0] field_index;
		logic [31:0] field_value;
		logic        field_end;
		logic        done_res;
		logic [2:0]  status;
		logic [17:0] cert_size;
		logic [17:0] byte_count;
	} result_t;

	// fixed field length, zero for variable fields
	function automatic logic [2:0] fixed_len(input logic [4:0] p);
		logic [2:0] l;
		case (p)
			5'd3, 5'd9, 5'd14, 5'd16, 5'd19: l = 3'd2;
			5'd6, 5'd7:                      l = 3'd4;
			5'd0, 5'd1, 5'd2, 5'd4, 5'd8,
			5'd10, 5'd12, 5'd13:             l = 3'd1;
			default:                         l = 3'd0;
		endcase
		return l;
	endfunction

	function automatic logic is_assembled(input logic [4:0] p);
		return p == PH_ISS_NLEN || p == PH_NBEFORE || p == PH_NAFTER ||
			p == PH_SUB_NLEN || p == PH_EXP_LEN || p == PH_MOD_LEN || p == PH_SIGLEN;
	endfunction

	function automatic logic is_length(input logic [4:0] p);
		return p == PH_ISS_NLEN || p == PH_SUB_NLEN || p == PH_EXP_LEN ||
			p == PH_MOD_LEN || p == PH_SIGLEN;
	endfunction

	// phase that follows a completed field
	function automatic logic [4:0] after_phase(input logic [4:0] p);
		logic [4:0] n;
		if (p == PH_MODULUS) begin
			n = PH_SIGLEN;
		end else if (p >= PH_SIG) begin
			n = PH_DONE;
		end else begin
			n = p + 5'd1;
		end
		return n;
	endfunction

endpackage

@@ design/wcfp_fifo.sv @@
// ---------------------------------------------------------------------------
// wcfp_fifo
// Small register queue with push/full and pop/empty, head shown directly.
// ---------------------------------------------------------------------------
module wcfp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW:0]      count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == (AW+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// storage, no reset on payload
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (AW+1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (AW+1)'(1);
			end
		end
	end
endmodule

@@ design/wcfp_front.sv @@
// ---------------------------------------------------------------------------
// wcfp_front
// Accepts raw bytes, tags them with the byte-level checks and queues them.
// ---------------------------------------------------------------------------
module wcfp_front #(
	parameter int DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [7:0]          data_byte,
	input  logic                last,
	input  logic [7:0]          text_id_code,
	input  logic [7:0]          rsa_key_code,
	input  logic                mid_pop,
	output wcfp_pkg::mid_item_t mid_item,
	output logic                mid_empty
);
	import wcfp_pkg::*;

	mid_item_t cls;
	logic [$bits(mid_item_t)-1:0] rd_bits;

	// byte classification against the configured codes
	always_comb begin
		cls.data_byte   = data_byte;
		cls.last        = last;
		cls.id_ok       = (data_byte == text_id_code);
		cls.key_ok      = (data_byte == rsa_key_code);
		cls.is_reserved = (data_byte == PARAM_RESERVED);
	end

	wcfp_fifo #(
		.WIDTH ($bits(mid_item_t)),
		.DEPTH (DEPTH)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cls),
		.full   (full),
		.pop    (mid_pop),
		.rdata  (rd_bits),
		.empty  (mid_empty)
	);

	assign mid_item = mid_item_t'(rd_bits);
endmodule

@@ design/wcfp_back.sv @@
// ---------------------------------------------------------------------------
// wcfp_back
// Field parser: walks the certificate phases one byte per cycle while bytes
// wait and the result queue has room, and writes one result item per byte.
// ---------------------------------------------------------------------------
module wcfp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [17:0]         expected_length,
	input  wcfp_pkg::mid_item_t item,
	input  logic                item_valid,
	output logic                item_pop,
	input  logic                res_full,
	output logic                res_push,
	output wcfp_pkg::result_t   res
);
	import wcfp_pkg::*;

	logic [4:0]  phase_q,     phase_d;
	logic [15:0] remaining_q, remaining_d;
	logic [15:0] position_q,  position_d;
	logic [31:0] assembly_q,  assembly_d;
	logic [17:0] consumed_q,  consumed_d;
	logic [17:0] size_q,      size_d;
	logic [2:0]  err_q,       err_d;

	logic        fire;
	logic [2:0]  flen;
	logic [15:0] len16;
	logic [16:0] pos_inc;
	logic [31:0] asm_new;
	logic [4:0]  next_ph;
	logic [2:0]  err_now;

	assign fire     = item_valid && !res_full;
	assign item_pop = fire;
	assign res_push = fire;

	// next state and result for the byte at the head of the queue
	always_comb begin
		consumed_d  = (consumed_q == COUNT_MAX) ? consumed_q : consumed_q + 18'd1;
		phase_d     = phase_q;
		remaining_d = remaining_q;
		position_d  = position_q;
		assembly_d  = assembly_q;
		size_d      = size_q;
		err_d       = err_q;
		next_ph     = phase_q;
		err_now     = ST_OK;
		asm_new     = {assembly_q[23:0], item.data_byte};
		flen        = fixed_len(phase_q);
		len16       = (flen != 3'd0) ? {13'd0, flen} : remaining_q;
		pos_inc     = {1'b0, position_q} + 17'd1;

		res.field_code  = PH_DONE;
		res.field_byte  = item.data_byte;
		res.field_index = '0;
		res.field_value = '0;
		res.field_end   = 1'b0;
		res.done_res    = 1'b0;

		if (phase_q != PH_DONE) begin
			res.field_code  = phase_q;
			res.field_index = position_q;
			if (is_assembled(phase_q)) begin
				assembly_d      = asm_new;
				res.field_value = asm_new;
			end
			res.field_end = (pos_inc >= {1'b0, len16});

			// field content checks
			if ((phase_q == PH_ISS_ID || phase_q == PH_SUB_ID) && !item.id_ok) begin
				err_now = ST_BAD_ID;
			end else if (phase_q == PH_KEY_ALG && !item.key_ok) begin
				err_now = ST_BAD_KEY;
			end else if (phase_q == PH_PARAM && item.is_reserved) begin
				err_now = ST_PARAM;
			end

			if (err_now != ST_OK) begin
				err_d         = err_now;
				phase_d       = PH_DONE;
				res.done_res  = 1'b1;
				res.field_end = 1'b1;
			end else if (res.field_end) begin
				next_ph    = after_phase(phase_q);
				position_d = '0;
				// a zero length skips the variable field behind it
				if (is_length(phase_q)) begin
					if (asm_new == '0) begin
						next_ph = after_phase(next_ph);
					end else begin
						remaining_d = asm_new[15:0];
					end
				end
				if (is_assembled(phase_q)) begin
					assembly_d = '0;
				end
				if (next_ph == PH_SIGLEN) begin
					size_d = consumed_d;
				end
				if (next_ph == PH_DONE) begin
					res.done_res = 1'b1;
					if (expected_length != '0 && consumed_d != expected_length) begin
						err_d = ST_LEN;
					end
				end
				phase_d = next_ph;
			end else begin
				position_d = pos_inc[15:0];
			end
		end

		// buffer ended before the parse finished
		if (item.last && phase_d != PH_DONE && err_d == ST_OK) begin
			err_d        = ST_TRUNC;
			res.done_res = 1'b1;
		end

		res.status     = err_d;
		res.cert_size  = size_d;
		res.byte_count = consumed_d;
	end

	// parse state, cleared after the last byte of a buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_VERSION;
			remaining_q <= '0;
			position_q  <= '0;
			assembly_q  <= '0;
			consumed_q  <= '0;
			size_q      <= '0;
			err_q       <= ST_OK;
		end else if (fire) begin
			if (item.last) begin
				phase_q     <= PH_VERSION;
				remaining_q <= '0;
				position_q  <= '0;
				assembly_q  <= '0;
				consumed_q  <= '0;
				size_q      <= '0;
				err_q       <= ST_OK;
			end else begin
				phase_q     <= phase_d;
				remaining_q <= remaining_d;
				position_q  <= position_d;
				assembly_q  <= assembly_d;
				consumed_q  <= consumed_d;
				size_q      <= size_d;
				err_q       <= err_d;
			end
		end
	end
endmodule

@@ design/wtls_certificate_field_parser.sv @@
// ---------------------------------------------------------------------------
// wtls_certificate_field_parser
// Tags each certificate byte with its field, assembles times and lengths,
// checks codes and total length, and reports the size before the signature.
//
//   channel   handshake         payload
//   input     push / full       data_byte, last
//   result    empty / pop       field_code .. byte_count
//   config    cfg_we            cfg_addr, cfg_wdata
//
// One item per cycle sustained while the result queue is not full; an accepted
// item is registered in the input queue, then parsed and registered in the result
// queue, from which it can be popped. The parser state is registered.
// The input queue keeps accepting while results wait; it fills only when the
// result queue is full and not popped. Reset empties both queues, clears the
// parse state and loads the register defaults.
// ---------------------------------------------------------------------------
module wtls_certificate_field_parser #(
	parameter int MID_DEPTH = 2,
	parameter int OUT_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        last,
	output logic        empty,
	input  logic        pop,
	output logic [4:0]  field_code,
	output logic [7:0]  field_byte,
	output logic [15:0] field_index,
	output logic [31:0] field_value,
	output logic        field_end,
	output logic        done_res,
	output logic [2:0]  status,
	output logic [17:0] cert_size,
	output logic [17:0] byte_count,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [17:0] cfg_wdata
);
	import wcfp_pkg::*;

`include "wtls_certificate_field_parser_assert.svh"

	logic [17:0] expected_length_q;
	logic [7:0]  text_id_code_q;
	logic [7:0]  rsa_key_code_q;

	mid_item_t   mid_item;
	logic        mid_empty;
	logic        mid_pop;
	result_t     res;
	logic        res_push;
	logic        res_full;
	logic [$bits(result_t)-1:0] out_bits;
	result_t     out_item;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_length_q <= 18'd0;
			text_id_code_q    <= 8'd1;
			rsa_key_code_q    <= 8'd2;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_EXP_LEN:  expected_length_q <= cfg_wdata;
				REG_TEXT_ID:  text_id_code_q    <= cfg_wdata[7:0];
				REG_RSA_CODE: rsa_key_code_q    <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	wcfp_front #(
		.DEPTH (MID_DEPTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.data_byte    (data_byte),
		.last         (last),
		.text_id_code (text_id_code_q),
		.rsa_key_code (rsa_key_code_q),
		.mid_pop      (mid_pop),
		.mid_item     (mid_item),
		.mid_empty    (mid_empty)
	);

	wcfp_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.expected_length (expected_length_q),
		.item            (mid_item),
		.item_valid      (!mid_empty),
		.item_pop        (mid_pop),
		.res_full        (res_full),
		.res_push        (res_push),
		.res             (res)
	);

	// result queue
	wcfp_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res),
		.full   (res_full),
		.pop    (pop),
		.rdata  (out_bits),
		.empty  (empty)
	);

	assign out_item    = result_t'(out_bits);
	assign field_code  = out_item.field_code;
	assign field_byte  = out_item.field_byte;
	assign field_index = out_item.field_index;
	assign field_value = out_item.field_value;
	assign field_end   = out_item.field_end;
	assign done_res    = out_item.done_res;
	assign status      = out_item.status;
	assign cert_size   = out_item.cert_size;
	assign byte_count  = out_item.byte_count;

	// checks
	`WCFP_ASSERT(a_no_push_when_full, clk, arst_n, res_push, !res_full, "result pushed into full queue")
	`WCFP_ASSERT(a_trail_no_end, clk, arst_n, res_push && res.field_code == PH_DONE, !res.field_end && !res.done_res, "trailing byte marked as field end")
	`WCFP_ASSERT(a_full_not_empty, clk, arst_n, full, !empty, "input queue full with no result waiting")
endmodule
